FILE: rtl/mhpr_pkg.sv
package mhpr_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int STG_W = $clog2(CORDIC_STAGES + 1);

    localparam logic OP_MAG   = 1'b0;
    localparam logic OP_POINT = 1'b1;

    localparam logic [0:0] REG_BIAS     = 1'b0;
    localparam logic [0:0] REG_INTERVAL = 1'b1;

    localparam logic [15:0] BIAS_RESET     = 16'd49258;
    localparam logic [23:0] INTERVAL_RESET = 24'd100000;

    localparam logic signed [17:0] UNIT_POS = 18'sd65536;
    localparam logic signed [17:0] UNIT_NEG = -18'sd65536;
    localparam logic signed [42:0] INV_GAIN = 43'sh26DD3B6A;

    typedef struct packed {
        logic               operation;
        logic signed [15:0] mag_x;
        logic signed [15:0] mag_y;
        logic [31:0]        sample_time;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } t_in_item;

    typedef struct packed {
        logic               result_kind;
        logic signed [31:0] rotated_x;
        logic signed [31:0] rotated_y;
        logic signed [31:0] rotated_z;
        logic [15:0]        current_heading;
        logic               heading_updated;
    } t_out_item;

    // classified item handed from front to back
    typedef struct packed {
        logic               is_point;
        logic               do_update;
        logic signed [15:0] mag_x;
        logic signed [15:0] mag_y;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } t_job;

    function automatic logic [31:0] atan_tab(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'h20000000;  5'd1:  v = 32'h12E4051D;
            5'd2:  v = 32'h09FB385B;  5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;  5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;  5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;  5'd9:  v = 32'h00145F2E;
            5'd10: v = 32'h000A2F98;  5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;  5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2F9;  5'd15: v = 32'h0000517C;
            5'd16: v = 32'h000028BE;  5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A2F;  5'd19: v = 32'h00000517;
            5'd20: v = 32'h0000028B;  5'd21: v = 32'h00000145;
            5'd22: v = 32'h000000A2;  5'd23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/mhpr_front.sv
module mhpr_front import mhpr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  t_in_item    i_item,
    input  logic [23:0] i_interval,
    input  logic        i_q_full,
    output logic        o_q_push,
    output t_job        o_job
);
    // interval gate: last accepted time lives here so points never wait
    logic [31:0] r_last;
    logic [31:0] elapsed;
    logic        take;

    assign o_full   = i_q_full;
    assign o_q_push = i_push && !i_q_full;
    assign elapsed  = i_item.sample_time - r_last;
    assign take     = (i_item.operation == OP_MAG) && (elapsed >= {8'd0, i_interval});

    always_comb begin
        o_job.is_point  = (i_item.operation == OP_POINT);
        o_job.do_update = take;
        o_job.mag_x     = i_item.mag_x;
        o_job.mag_y     = i_item.mag_y;
        o_job.point_x   = i_item.point_x;
        o_job.point_y   = i_item.point_y;
        o_job.point_z   = i_item.point_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
        end else if (o_q_push && take) begin
            r_last <= i_item.sample_time;
        end
    end
endmodule

FILE: rtl/mhpr_fifo.sv
module mhpr_fifo import mhpr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_data
);
    // two-entry queue
    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule

FILE: rtl/mhpr_back.sv
module mhpr_back import mhpr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_bias,
    input  logic        i_q_empty,
    input  t_job        i_job,
    output logic        o_q_pop,
    output logic        o_empty,
    input  logic        i_pop,
    output t_out_item   o_item
);
    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_SUM, S_VEC, S_ROT, S_FIN
    } t_state;

    t_state             r_state;
    logic [STG_W-1:0]   r_i;
    logic [15:0]        r_head;
    logic signed [17:0] r_cos, r_sin;
    logic signed [42:0] r_x, r_y, r_z;
    logic               r_flip;
    t_job               r_job;
    logic signed [49:0] r_p0, r_p1, r_p2, r_p3;
    logic signed [51:0] r_ax, r_ay;
    logic               r_ovalid;
    t_out_item          r_out;

    logic signed [42:0] dx, dy, tab;
    logic [15:0]        raw;
    logic signed [31:0] zs;
    logic signed [31:0] sat_x, sat_y;
    logic signed [28:0] cq, sq;
    logic signed [17:0] cc, sc;
    logic signed [42:0] mx, my;

    assign o_empty = !r_ovalid;
    assign o_item  = r_out;
    assign o_q_pop = (r_state == S_IDLE) && !i_q_empty && !r_ovalid;

    assign dx  = r_y >>> r_i;
    assign dy  = r_x >>> r_i;
    assign tab = {11'd0, atan_tab(5'(r_i))};
    assign raw = 16'((r_z[31:0] + 32'h8000) >> 16);
    assign zs  = {raw - i_bias, 16'd0};
    assign mx  = {{3{i_job.mag_x[15]}}, i_job.mag_x, 24'd0};
    assign my  = {{3{i_job.mag_y[15]}}, i_job.mag_y, 24'd0};

    function automatic logic signed [31:0] sat_q(input logic signed [51:0] a);
        logic signed [51:0] v;
        v = (a + 52'sd32768) >>> 16;
        if (v > 52'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -52'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [17:0] clampu(input logic signed [28:0] v);
        if (v > 29'sd65536) return UNIT_POS;
        if (v < -29'sd65536) return UNIT_NEG;
        return v[17:0];
    endfunction

    assign cq    = 29'((r_x + 43'sd8192) >>> 14);
    assign sq    = 29'((r_y + 43'sd8192) >>> 14);
    assign cc    = r_flip ? -clampu(cq) : clampu(cq);
    assign sc    = r_flip ? -clampu(sq) : clampu(sq);
    assign sat_x = sat_q(r_ax);
    assign sat_y = sat_q(r_ay);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_head   <= '0;
            r_cos    <= UNIT_POS;
            r_sin    <= '0;
            r_i      <= '0;
        end else begin
            if (r_ovalid && i_pop) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_q_pop) begin
                        r_job <= i_job;
                        if (i_job.is_point) begin
                            r_p0    <= 50'(r_cos) * 50'(i_job.point_x);
                            r_p1    <= 50'(r_sin) * 50'(i_job.point_y);
                            r_p2    <= 50'(r_cos) * 50'(i_job.point_y);
                            r_p3    <= 50'(r_sin) * 50'(i_job.point_x);
                            r_state <= S_SUM;
                        end else if (!i_job.do_update) begin
                            r_out    <= '{1'b0, 32'sd0, 32'sd0, 32'sd0, r_head, 1'b0};
                            r_ovalid <= 1'b1;
                        end else begin
                            r_i <= '0;
                            if (i_job.mag_x == 16'sd0 && i_job.mag_y == 16'sd0) begin
                                r_x <= '0; r_y <= '0; r_z <= '0;
                                r_i <= STG_W'(CORDIC_STAGES);
                            end else if (i_job.mag_x < 0) begin
                                r_x <= -mx; r_y <= -my; r_z <= 43'sh80000000;
                            end else begin
                                r_x <= mx; r_y <= my; r_z <= '0;
                            end
                            r_state <= S_VEC;
                        end
                    end
                end
                S_SUM: begin
                    r_ax    <= 52'(r_p0) + 52'(r_p1);
                    r_ay    <= 52'(r_p2) - 52'(r_p3);
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_out <= '{1'b1, sat_x, sat_y, r_job.point_z, r_head, 1'b0};
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                S_VEC: begin
                    if (r_i == STG_W'(CORDIC_STAGES)) begin
                        r_head <= raw - i_bias;
                        r_i    <= '0;
                        r_x    <= INV_GAIN;
                        r_y    <= '0;
                        r_flip <= 1'b0;
                        if (zs > 32'sh40000000) begin
                            r_z <= 43'(zs) - 43'sh80000000; r_flip <= 1'b1;
                        end else if (zs < -32'sh40000000) begin
                            r_z <= 43'(zs) + 43'sh80000000; r_flip <= 1'b1;
                        end else begin
                            r_z <= 43'(zs);
                        end
                        r_state <= S_ROT;
                    end else begin
                        if (r_y >= 0) begin
                            r_x <= r_x + dx; r_y <= r_y - dy;
                            r_z <= 43'({11'd0, 32'(r_z[31:0] + tab[31:0])});
                        end else begin
                            r_x <= r_x - dx; r_y <= r_y + dy;
                            r_z <= 43'({11'd0, 32'(r_z[31:0] - tab[31:0])});
                        end
                        r_i <= r_i + 1'b1;
                    end
                end
                S_ROT: begin
                    if (r_i == STG_W'(CORDIC_STAGES)) begin
                        r_state <= S_FIN;
                    end else begin
                        if (r_z >= 0) begin
                            r_x <= r_x - dx; r_y <= r_y + dy; r_z <= r_z - tab;
                        end else begin
                            r_x <= r_x + dx; r_y <= r_y - dy; r_z <= r_z + tab;
                        end
                        r_i <= r_i + 1'b1;
                    end
                end
                S_FIN: begin
                    r_cos    <= cc;
                    r_sin    <= sc;
                    r_out    <= '{1'b0, 32'sd0, 32'sd0, 32'sd0, r_head, 1'b1};
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: rtl/magnetic_heading_point_rotator_top.sv
// Magnetic heading tracker and point rotator.
// Input queue side: drive push with an item on i_in_item; it is taken on
// a clock edge where push is high and full low. operation 0 is a
// magnetometer sample, 1 a point.
// Result queue side: while empty is low the oldest result sits on
// o_out_item; pop on such an edge takes it.
// Config: i_cfg_valid/o_cfg_ready with i_cfg_index, i_cfg_data; 0 is the
// heading bias, 1 the minimum sample interval. Write only while idle.
// A front stage applies the interval gate and pushes a job into a
// two-entry queue; the back stage runs the job.
// Steps: a point goes through four products, sum, then round/saturate.
// A rejected sample's result is registered as its job is popped. An
// accepted sample runs vectoring CORDIC, then rotation CORDIC, one
// stage per cycle on one shared datapath.
// Throughput: one item at a time in the back stage; a waiting result
// blocks the back stage until popped, and the queue then fills and raises
// full. Reset (synchronous, active low) restores heading 0, cos 1,
// sin 0, last time 0 and the register defaults.
module magnetic_heading_point_rotator_top import mhpr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  t_in_item    i_in_item,
    output logic        empty,
    input  logic        pop,
    output t_out_item   o_out_item,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);
    logic [15:0] r_bias;
    logic [23:0] r_interval;
    logic        q_full, q_push, q_empty, q_pop;
    t_job        f_job, b_job;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias     <= BIAS_RESET;
            r_interval <= INTERVAL_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_BIAS:     r_bias     <= i_cfg_data[15:0];
                REG_INTERVAL: r_interval <= i_cfg_data;
                default: ;
            endcase
        end
    end

    mhpr_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .o_full(full),
        .i_item(i_in_item), .i_interval(r_interval), .i_q_full(q_full),
        .o_q_push(q_push), .o_job(f_job)
    );

    mhpr_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(q_push), .i_data(f_job),
        .o_full(q_full), .i_pop(q_pop), .o_empty(q_empty), .o_data(b_job)
    );

    mhpr_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_bias(r_bias), .i_q_empty(q_empty),
        .i_job(b_job), .o_q_pop(q_pop), .o_empty(empty), .i_pop(pop),
        .o_item(o_out_item)
    );
endmodule
